[design/ssb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssb_pkg
// Shared types and constants of the bidirectional substring search block.
// ----------------------------------------------------------------------------
package ssb_pkg;

   localparam int BUF_DEPTH   = 256;
   localparam int ADDR_W      = $clog2(BUF_DEPTH);
   localparam int PTR_W       = ADDR_W + 1;
   localparam int MAX_PATTERN = 8;
   localparam int LEN_W       = 4;

   // operation codes
   localparam logic [1:0] OP_WRITE      = 2'd0;
   localparam logic [1:0] OP_SEARCH     = 2'd1;
   localparam logic [1:0] OP_SET_OFFSET = 2'd2;

   // direction codes; the unused code scans backward like MODE_BACKWARD
   localparam logic [1:0] MODE_GLOBAL   = 2'd0;
   localparam logic [1:0] MODE_FORWARD  = 2'd1;
   localparam logic [1:0] MODE_BACKWARD = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  address;
      logic [7:0]  data_byte;
      logic [63:0] pattern;
      logic [3:0]  pattern_length;
      logic [1:0]  direction_mode;
      logic        case_insensitive;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [7:0] position;
   } rsp_type;

   // one byte of the compare window and whether it lies inside the buffer
   typedef struct packed {
      logic       vld;
      logic [7:0] data;
   } win_slot_type;

endpackage

[design/substring_search_bidirectional.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// substring_search_bidirectional
// Byte buffer with a current offset and a windowed pattern search.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request: write a byte, set the offset or search.
//   rsp_* returns one result per request: found flag and the offset after it.
//   Both channels accept at a clock edge where valid is high and stall low.
// Flow:
//   A write or set-offset request passes through the done state into the
//   output register. A search streams the buffer through its single read
//   port, one byte per cycle, into an 8-byte window that 8 compare lanes
//   check every cycle; a forward search first fills the whole window, a
//   backward search only pattern_length bytes, and each then tries its
//   start positions in turn. Only one request is in work at a time; the
//   next is taken while the last result still waits in the output register.
// Reset:
//   Clears the offset and the handshake state; buffer contents stay undefined
//   until written.
// Stall:
//   A stalled result holds in the output register; a finished search waits
//   in its done state and no new request is taken until the result moves on.
// ----------------------------------------------------------------------------
module substring_search_bidirectional (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ssb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ssb_pkg::rsp_type rsp_data
);

   localparam int NL = ssb_pkg::MAX_PATTERN;

   ssb_pkg::state_type state_ff, state_in;

   logic [63:0]                     pat_ff, pat_in;
   logic [ssb_pkg::LEN_W-1:0]       len_ff, len_in;
   logic [ssb_pkg::LEN_W-1:0]       need_ff, need_in;
   logic [ssb_pkg::LEN_W-1:0]       fill_ff, fill_in;
   logic                            back_ff, back_in;
   logic                            fold_ff, fold_in;
   logic [ssb_pkg::ADDR_W-1:0]      offset_ff, offset_in;
   logic                            found_ff, found_in;
   logic [ssb_pkg::PTR_W-1:0]       cand_ff, cand_in;
   logic [ssb_pkg::PTR_W-1:0]       rd_addr_ff, rd_addr_in;
   logic                            pend_ff, pend_in;
   logic                            inr_ff, inr_in;
   ssb_pkg::win_slot_type           win_ff [NL];
   ssb_pkg::win_slot_type           win_in [NL];
   logic                            rsp_valid_ff, rsp_valid_in;
   ssb_pkg::rsp_type                rsp_data_ff, rsp_data_in;

   logic                            req_acc;
   logic                            out_free;
   logic                            eval;
   logic                            hit;
   logic                            at_end;
   logic                            at_term;
   logic                            is_back;
   logic                            search_go;
   logic [ssb_pkg::LEN_W-1:0]       len_sat;
   logic [7:0]                      rd_data;
   logic [NL-1:0]                   lane_hit;
   ssb_pkg::win_slot_type           new_slot;

   // handshake
   assign req_stall = (state_ff != ssb_pkg::ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // decode a new search request
   assign len_sat = (req_data.pattern_length > ssb_pkg::LEN_W'(NL))
                  ? ssb_pkg::LEN_W'(NL) : req_data.pattern_length;
   assign is_back = (req_data.direction_mode != ssb_pkg::MODE_GLOBAL)
                 && (req_data.direction_mode != ssb_pkg::MODE_FORWARD);
   assign search_go = (req_data.operation == ssb_pkg::OP_SEARCH)
                   && (req_data.pattern_length != '0)
                   && !(is_back && (offset_ff < ssb_pkg::ADDR_W'(len_sat)));

   // text buffer
   ssb_buffer u_buffer (
      .clock   (clock),
      .wr_en   (req_acc && (req_data.operation == ssb_pkg::OP_WRITE)),
      .wr_addr (req_data.address),
      .wr_data (req_data.data_byte),
      .rd_addr (rd_addr_ff[ssb_pkg::ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // compare lanes, one per pattern byte
   for (genvar k = 0; k < NL; k++) begin : g_lane
      ssb_lane u_lane (
         .slot     (win_ff[k]),
         .pat_byte (pat_ff[8*k +: 8]),
         .fold     (fold_ff),
         .enable   (ssb_pkg::LEN_W'(k) < len_ff),
         .hit      (lane_hit[k])
      );
   end

   // merge the lanes
   assign hit = &lane_hit;

   assign eval     = (state_ff == ssb_pkg::ST_SCAN) && (fill_ff >= need_ff);
   assign at_end   = cand_ff[ssb_pkg::ADDR_W];
   assign at_term  = (win_ff[0].data == 8'd0);
   assign new_slot = '{vld: inr_ff, data: rd_data};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ssb_pkg::ST_IDLE: begin
            if (req_acc) begin
               state_in = search_go ? ssb_pkg::ST_SCAN : ssb_pkg::ST_DONE;
            end
         end
         ssb_pkg::ST_SCAN: begin
            if (eval) begin
               if (back_ff) begin
                  if (hit || (cand_ff == '0)) begin
                     state_in = ssb_pkg::ST_DONE;
                  end
               end else if (at_end || at_term || hit) begin
                  state_in = ssb_pkg::ST_DONE;
               end
            end
         end
         ssb_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = ssb_pkg::ST_IDLE;
            end
         end
         default: state_in = ssb_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      pat_in       = pat_ff;
      len_in       = len_ff;
      need_in      = need_ff;
      fill_in      = fill_ff;
      back_in      = back_ff;
      fold_in      = fold_ff;
      offset_in    = offset_ff;
      found_in     = found_ff;
      cand_in      = cand_ff;
      rd_addr_in   = rd_addr_ff;
      pend_in      = pend_ff;
      inr_in       = inr_ff;
      win_in       = win_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ssb_pkg::ST_IDLE: begin
            if (req_acc) begin
               found_in = 1'b0;
               pat_in   = req_data.pattern;
               len_in   = len_sat;
               fold_in  = req_data.case_insensitive;
               back_in  = is_back;
               need_in  = is_back ? len_sat : ssb_pkg::LEN_W'(NL);
               fill_in  = '0;
               pend_in  = 1'b0;
               if (req_data.operation == ssb_pkg::OP_SET_OFFSET) begin
                  offset_in = req_data.address;
               end
               if (is_back) begin
                  cand_in    = {1'b0, offset_ff - ssb_pkg::ADDR_W'(len_sat)};
                  rd_addr_in = {1'b0, offset_ff} - ssb_pkg::PTR_W'(1);
               end else begin
                  cand_in    = (req_data.direction_mode == ssb_pkg::MODE_GLOBAL)
                             ? '0 : {1'b0, offset_ff};
                  rd_addr_in = (req_data.direction_mode == ssb_pkg::MODE_GLOBAL)
                             ? '0 : {1'b0, offset_ff};
               end
            end
         end
         ssb_pkg::ST_SCAN: begin
            // stream one byte per cycle
            inr_in     = !rd_addr_ff[ssb_pkg::ADDR_W];
            pend_in    = 1'b1;
            rd_addr_in = back_ff ? rd_addr_ff - ssb_pkg::PTR_W'(1)
                                 : rd_addr_ff + ssb_pkg::PTR_W'(1);
            // shift the window
            if (pend_ff) begin
               if (fill_ff < ssb_pkg::LEN_W'(NL)) begin
                  fill_in = fill_ff + ssb_pkg::LEN_W'(1);
               end
               if (back_ff) begin
                  for (int k = NL - 1; k > 0; k--) begin
                     win_in[k] = win_ff[k-1];
                  end
                  win_in[0] = new_slot;
               end else begin
                  for (int k = 0; k < NL - 1; k++) begin
                     win_in[k] = win_ff[k+1];
                  end
                  win_in[NL-1] = new_slot;
               end
            end
            // check the candidate
            if (eval) begin
               if (back_ff) begin
                  if (hit) begin
                     found_in  = 1'b1;
                     offset_in = cand_ff[ssb_pkg::ADDR_W-1:0];
                  end
                  cand_in = cand_ff - ssb_pkg::PTR_W'(1);
               end else begin
                  if (!at_end && !at_term && hit) begin
                     found_in  = 1'b1;
                     offset_in = cand_ff[ssb_pkg::ADDR_W-1:0];
                  end
                  cand_in = cand_ff + ssb_pkg::PTR_W'(1);
               end
            end
         end
         ssb_pkg::ST_DONE: begin
            // hand the result to the output register
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{found: found_ff, position: offset_ff};
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssb_pkg::ST_IDLE;
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         fill_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         offset_ff    <= offset_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         fill_ff      <= fill_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pat_ff      <= pat_in;
      len_ff      <= len_in;
      need_ff     <= need_in;
      back_ff     <= back_in;
      fold_ff     <= fold_in;
      found_ff    <= found_in;
      cand_ff     <= cand_in;
      rd_addr_ff  <= rd_addr_in;
      inr_ff      <= inr_in;
      win_ff      <= win_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[design/ssb_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssb_lane
// One compare lane: matches one window byte against one pattern byte.
// ----------------------------------------------------------------------------
module ssb_lane (
   input  ssb_pkg::win_slot_type slot,
   input  logic [7:0]            pat_byte,
   input  logic                  fold,
   input  logic                  enable,
   output logic                  hit
);

   function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic f);
      if (f && b >= 8'h61 && b <= 8'h7A) begin
         return b - 8'h20;
      end
      return b;
   endfunction

   // a lane beyond the pattern length always agrees; bytes past the end never do
   assign hit = !enable
              || (slot.vld && (fold_byte(slot.data, fold) == fold_byte(pat_byte, fold)));

endmodule

[design/ssb_buffer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssb_buffer
// Text buffer: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ssb_buffer (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ssb_pkg::ADDR_W-1:0] wr_addr,
   input  logic [7:0]                 wr_data,
   input  logic [ssb_pkg::ADDR_W-1:0] rd_addr,
   output logic [7:0]                 rd_data
);

   logic [7:0] mem [ssb_pkg::BUF_DEPTH];
   logic [7:0] rd_data_ff;

   // store a byte
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read every cycle
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[dv/ssb_response_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssb_response_checker
// Watches both channels of the substring search block. It keeps its own copy
// of the text buffer and the offset. For every accepted request it works out
// the response, and it compares each accepted response with the oldest one
// still due.
// ----------------------------------------------------------------------------
module ssb_response_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  ssb_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  ssb_pkg::rsp_type rsp_data,
   output int unsigned      fail_count,
   output int unsigned      outstanding,
   output int unsigned      match_count
);

   logic [7:0]                 text_image [ssb_pkg::BUF_DEPTH];
   logic [ssb_pkg::ADDR_W-1:0] cur_offset;
   ssb_pkg::rsp_type           due_results [$];

   // fold lower-case letters to upper case when folding is on
   function automatic logic [7:0] upcase(input logic [7:0] b, input logic fold);
      if (fold && b >= 8'h61 && b <= 8'h7A) begin
         return b - 8'h20;
      end
      return b;
   endfunction

   // a compare that runs past the buffer end is a miss
   function automatic logic pattern_fits(input int start, input logic [63:0] pat,
                                         input int len, input logic fold);
      int k;
      for (k = 0; k < len; k++) begin
         if (start + k >= ssb_pkg::BUF_DEPTH) begin
            return 1'b0;
         end
         if (upcase(text_image[start + k], fold) != upcase(pat[8*k +: 8], fold)) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // apply one request to the buffer and offset and return its response
   function automatic ssb_pkg::rsp_type compute_response(input ssb_pkg::req_type r);
      ssb_pkg::rsp_type res;
      int               len;
      int               i;
      logic             hit;
      hit = 1'b0;
      case (r.operation)
         ssb_pkg::OP_WRITE: begin
            text_image[r.address] = r.data_byte;
         end
         ssb_pkg::OP_SET_OFFSET: begin
            cur_offset = r.address;
         end
         ssb_pkg::OP_SEARCH: begin
            len = (r.pattern_length > ssb_pkg::MAX_PATTERN)
                ? ssb_pkg::MAX_PATTERN : int'(r.pattern_length);
            if (len == 0) begin
               hit = 1'b0;
            end else if (r.direction_mode == ssb_pkg::MODE_GLOBAL ||
                         r.direction_mode == ssb_pkg::MODE_FORWARD) begin
               // scan up, stop at the terminator or the buffer end
               i = (r.direction_mode == ssb_pkg::MODE_GLOBAL) ? 0 : int'(cur_offset);
               while (!hit && i < ssb_pkg::BUF_DEPTH && text_image[i] != 8'h00) begin
                  if (pattern_fits(i, r.pattern, len, r.case_insensitive)) begin
                     hit        = 1'b1;
                     cur_offset = i[ssb_pkg::ADDR_W-1:0];
                  end else begin
                     i++;
                  end
               end
            end else if (int'(cur_offset) >= len) begin
               // scan down from just below the offset, terminators ignored
               i = int'(cur_offset) - len;
               while (!hit && i >= 0) begin
                  if (pattern_fits(i, r.pattern, len, r.case_insensitive)) begin
                     hit        = 1'b1;
                     cur_offset = i[ssb_pkg::ADDR_W-1:0];
                  end
                  i--;
               end
            end
         end
         default: begin
         end
      endcase
      res.found    = hit;
      res.position = cur_offset;
      return res;
   endfunction

   // compare responses first, then queue the response of a new request
   always @(posedge clock) begin
      ssb_pkg::rsp_type exp_rsp;
      if (reset) begin
         cur_offset = '0;
         due_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               $error("response with no request outstanding: found %0d, position %0d",
                      rsp_data.found, rsp_data.position);
               fail_count++;
            end else begin
               exp_rsp = due_results.pop_front();
               if (rsp_data.found !== exp_rsp.found) begin
                  $error("found: expected %0d, actual %0d", exp_rsp.found, rsp_data.found);
                  fail_count++;
               end
               if (rsp_data.position !== exp_rsp.position) begin
                  $error("position: expected %0d, actual %0d",
                         exp_rsp.position, rsp_data.position);
                  fail_count++;
               end
               if (exp_rsp.found) begin
                  match_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            due_results.push_back(compute_response(req_data));
         end
      end
      outstanding = due_results.size();
   end

endmodule

[dv/tb_substring_search_bidirectional.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_substring_search_bidirectional
// Preloads the whole text buffer, then runs directed searches over terminators,
// the buffer end, case folding and the backward edge cases. Random writes,
// offset moves and searches built from the buffer text follow, with random
// gaps on both sides and a long receiver hold-off. A checker module compares.
// ----------------------------------------------------------------------------
module tb_substring_search_bidirectional;

   localparam int ITEM_TARGET      = 1950;
   localparam int MAX_GAP          = 11;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int HOLD_AT_ITEM     = 900;
   localparam int PAUSE_AT_ITEM    = 1400;
   localparam int SETTLE_CYCLES    = 300;
   localparam int CYCLE_LIMIT      = 3_000_000;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   ssb_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   ssb_pkg::rsp_type rsp_data;

   int unsigned fail_count;
   int unsigned outstanding;
   int unsigned match_count;

   logic [7:0]  text_shadow [ssb_pkg::BUF_DEPTH];
   bit          send_gaps_on = 1'b1;
   bit          rsp_gaps_on  = 1'b1;
   bit          hold_request = 1'b0;
   bit          rsp_held     = 1'b0;
   bit          rsp_taken    = 1'b0;
   int          stall_left   = 0;
   int unsigned cycle_count  = 0;
   int          items_sent   = 0;
   int          writes_sent  = 0;
   int          offsets_sent = 0;
   int          searches_sent = 0;

   substring_search_bidirectional i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   ssb_response_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .outstanding (outstanding),
      .match_count (match_count)
   );

   always #5 clock = ~clock;

   // end the run if it hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // note each accepted response so the receiver can draw its next wait
   always @(posedge clock) begin
      rsp_taken <= rsp_valid && !rsp_stall;
   end

   // receiver: wait a random number of cycles after each response
   always @(negedge clock) begin
      if (rsp_taken) begin
         stall_left = rsp_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (rsp_held || stall_left > 0) begin
         rsp_stall <= 1'b1;
         if (stall_left > 0) begin
            stall_left--;
         end
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // long receiver hold-off, counted here while the sender keeps going
   initial begin
      wait (hold_request);
      @(negedge clock);
      rsp_held <= 1'b1;
      repeat (LONG_HOLD_CYCLES) @(negedge clock);
      rsp_held <= 1'b0;
   end

   // text byte: mostly a small alphabet so that searches hit, rarely a terminator
   function automatic logic [7:0] pick_text_byte();
      int pick;
      pick = $urandom_range(0, 63);
      if (pick == 0) begin
         return 8'h00;
      end else if (pick <= 8) begin
         return 8'($urandom_range(1, 255));
      end
      case ($urandom_range(0, 4))
         0:       return "a";
         1:       return "A";
         2:       return "b";
         3:       return "B";
         default: return "c";
      endcase
   endfunction

   // random request in range; callers overwrite the fields that matter
   function automatic ssb_pkg::req_type noise_request();
      ssb_pkg::req_type r;
      r.operation        = ssb_pkg::OP_WRITE;
      r.address          = 8'($urandom);
      r.data_byte        = 8'($urandom);
      r.pattern          = {$urandom, $urandom};
      r.pattern_length   = 4'($urandom_range(1, ssb_pkg::MAX_PATTERN));
      r.direction_mode   = 2'($urandom_range(0, 2));
      r.case_insensitive = 1'($urandom);
      return r;
   endfunction

   // pattern bytes from a string, unused upper bytes random
   function automatic logic [63:0] pack_pattern(input string s);
      logic [63:0] p;
      int          k;
      p = {$urandom, $urandom};
      for (k = 0; k < s.len(); k++) begin
         p[8*k +: 8] = s[k];
      end
      return p;
   endfunction

   // offer one request after a random gap and hold it until accepted
   task automatic send_request(input ssb_pkg::req_type r);
      int gap;
      gap = send_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      items_sent++;
      case (r.operation)
         ssb_pkg::OP_WRITE:      writes_sent++;
         ssb_pkg::OP_SET_OFFSET: offsets_sent++;
         default:                searches_sent++;
      endcase
   endtask

   task automatic send_write(input logic [7:0] addr, input logic [7:0] data);
      ssb_pkg::req_type r;
      r                 = noise_request();
      r.operation       = ssb_pkg::OP_WRITE;
      r.address         = addr;
      r.data_byte       = data;
      text_shadow[addr] = data;
      send_request(r);
   endtask

   task automatic send_set_offset(input logic [7:0] addr);
      ssb_pkg::req_type r;
      r           = noise_request();
      r.operation = ssb_pkg::OP_SET_OFFSET;
      r.address   = addr;
      send_request(r);
   endtask

   task automatic send_search(input logic [63:0] pat, input int len,
                              input logic [1:0] mode, input logic fold);
      ssb_pkg::req_type r;
      r                  = noise_request();
      r.operation        = ssb_pkg::OP_SEARCH;
      r.pattern          = pat;
      r.pattern_length   = 4'(len);
      r.direction_mode   = mode;
      r.case_insensitive = fold;
      send_request(r);
   endtask

   task automatic search_text(input string s, input logic [1:0] mode, input logic fold);
      send_search(pack_pattern(s), s.len(), mode, fold);
   endtask

   task automatic place_text(input int at, input string s);
      int k;
      for (k = 0; k < s.len(); k++) begin
         text_shadow[at + k] = s[k];
      end
   endtask

   // drop valid and wait until every due response has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   initial begin : stimulus
      int          a;
      int          j;
      int          k;
      int          n;
      int          len;
      int          start;
      int          shape;
      int          choice;
      int          next_redraw;
      int          top_offset;
      bit          hold_done;
      bit          pause_done;
      logic [7:0]  base;
      logic [7:0]  b;
      logic [63:0] pat;
      logic [1:0]  mode;
      logic        fold;

      hold_done   = 1'b0;
      pause_done  = 1'b0;
      next_redraw = 0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // preload every entry: alphabet text with landmarks for the directed searches
      for (a = 0; a < ssb_pkg::BUF_DEPTH; a++) begin
         case ($urandom_range(0, 4))
            0:       text_shadow[a] = "a";
            1:       text_shadow[a] = "A";
            2:       text_shadow[a] = "b";
            3:       text_shadow[a] = "B";
            default: text_shadow[a] = "c";
         endcase
      end
      place_text(0, "abc");
      place_text(20, "xyz");
      place_text(30, "{");
      place_text(40, "HIJKLMNO");
      place_text(99, "Z");
      text_shadow[100] = 8'h00;
      place_text(253, "QRS");
      for (a = 0; a < ssb_pkg::BUF_DEPTH; a++) begin
         send_write(8'(a), text_shadow[a]);
      end
      wait_for_drain();

      // terminator stops a global scan; forward scan from past it finds the tail
      search_text("QRS", ssb_pkg::MODE_GLOBAL, 1'b0);
      send_set_offset(8'd101);
      search_text("QRS", ssb_pkg::MODE_FORWARD, 1'b0);
      // compare running off the buffer end
      search_text("QRST", ssb_pkg::MODE_FORWARD, 1'b0);
      // backward scan crosses a terminator
      search_text("xyz", ssb_pkg::MODE_BACKWARD, 1'b0);
      // case folding on and off
      search_text("XYZ", ssb_pkg::MODE_GLOBAL, 1'b1);
      search_text("XYZ", ssb_pkg::MODE_GLOBAL, 1'b0);
      // zero byte inside the pattern matches the terminator
      pat        = pack_pattern("Z");
      pat[15:8]  = 8'h00;
      send_search(pat, 2, ssb_pkg::MODE_GLOBAL, 1'b0);
      // full-length pattern, folded
      search_text("hijklmno", ssb_pkg::MODE_GLOBAL, 1'b1);
      // backward with offset below the length, then exactly at it
      send_set_offset(8'd2);
      search_text("abcd", ssb_pkg::MODE_BACKWARD, 1'b0);
      send_set_offset(8'd3);
      search_text("abc", ssb_pkg::MODE_BACKWARD, 1'b0);
      // folding leaves non-letters alone
      search_text("[", ssb_pkg::MODE_GLOBAL, 1'b1);
      // forward scan starting on a terminator
      send_set_offset(8'd100);
      search_text("a", ssb_pkg::MODE_FORWARD, 1'b0);
      // extreme addresses and data, terminator at address 0
      send_write(8'd255, 8'hFF);
      send_write(8'd0, 8'h00);
      search_text("a", ssb_pkg::MODE_GLOBAL, 1'b0);
      send_write(8'd0, "a");
      send_set_offset(8'd255);
      send_search({64{1'b1}}, 1, ssb_pkg::MODE_FORWARD, 1'b0);
      send_search({64{1'b1}}, ssb_pkg::MAX_PATTERN, ssb_pkg::MODE_BACKWARD, 1'b1);
      search_text("Q", ssb_pkg::MODE_BACKWARD, 1'b0);
      send_set_offset(8'd0);
      wait_for_drain();

      // random mix, mostly searches for text taken from the buffer
      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= next_redraw) begin
            send_gaps_on = ($urandom_range(0, 3) != 0);
            rsp_gaps_on <= ($urandom_range(0, 3) != 0);
            next_redraw  = items_sent + 100;
         end
         if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
            hold_request <= 1'b1;
            hold_done     = 1'b1;
         end
         if (!pause_done && items_sent >= PAUSE_AT_ITEM) begin
            wait_for_drain();
            pause_done = 1'b1;
         end
         choice = $urandom_range(0, 99);
         if (choice < 25) begin
            // short burst of writes
            n    = $urandom_range(1, 4);
            base = 8'($urandom);
            for (j = 0; j < n; j++) begin
               send_write(base + 8'(j), pick_text_byte());
            end
         end else if (choice < 35) begin
            send_set_offset(8'($urandom));
         end else begin
            len   = ($urandom_range(0, 7) == 0) ? $urandom_range(5, ssb_pkg::MAX_PATTERN)
                                                : $urandom_range(1, 4);
            start = $urandom_range(0, ssb_pkg::BUF_DEPTH - 1);
            mode  = 2'($urandom_range(0, 2));
            fold  = 1'($urandom);
            pat   = {$urandom, $urandom};
            shape = $urandom_range(0, 9);
            if (shape < 9) begin
               for (k = 0; k < len; k++) begin
                  b = (start + k < ssb_pkg::BUF_DEPTH) ? text_shadow[start + k]
                                                       : 8'($urandom);
                  // flip the case of some letters
                  if (shape < 4 && $urandom_range(0, 1) == 1 &&
                      ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A))) begin
                     b = b ^ 8'h20;
                  end
                  pat[8*k +: 8] = b;
               end
            end
            if (shape == 8) begin
               pat[8*$urandom_range(0, len - 1) +: 8] = 8'($urandom);
            end
            // often place the offset so the scan direction can reach the text
            if ($urandom_range(0, 2) == 0) begin
               if (mode == ssb_pkg::MODE_BACKWARD) begin
                  top_offset = start + len + $urandom_range(0, 20);
                  send_set_offset(8'((top_offset > 255) ? 255 : top_offset));
               end else begin
                  send_set_offset(8'($urandom_range(0, start)));
               end
            end
            send_search(pat, len, mode, fold);
         end
      end

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Covered %0d requests: %0d writes, %0d offset moves, %0d searches, %0d hits.",
               items_sent, writes_sent, offsets_sent, searches_sent, match_count);
      $display("Scans ran in all three directions, folded and exact,");
      $display("with random gaps and a %0d-cycle hold.", LONG_HOLD_CYCLES);
      if (fail_count == 0 && outstanding == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[filelist.f]
design/ssb_pkg.sv
design/ssb_lane.sv
design/ssb_buffer.sv
design/substring_search_bidirectional.sv
dv/ssb_response_checker.sv
dv/tb_substring_search_bidirectional.sv
